[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RBB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rbb_pkg.sv]
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types, constants and register codes of the row box blur.
// ----------------------------------------------------------------------------
package rbb_pkg;

    localparam int PIX_W             = 8;
    localparam int PIX_MAX           = 255;
    localparam int NUM_PORT_CH       = 4;

    localparam int DEF_MAX_RADIUS    = 31;
    localparam int DEF_WINDOW_DEPTH  = 64;
    localparam int DEF_MAX_ROW_WIDTH = 4096;
    localparam int DEF_CHANNELS      = 4;

    localparam int RADIUS_W          = 5;
    localparam int SIZE_W            = 13;
    localparam int CFG_DATA_W        = 13;
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd2;

    localparam logic [RADIUS_W-1:0] RST_RADIUS    = 5'd1;
    localparam logic [SIZE_W-1:0]   RST_ROW_WIDTH = 13'd640;
    localparam logic [SIZE_W-1:0]   RST_ROW_COUNT = 13'd480;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[src/rbb_window_mem.sv]
// ----------------------------------------------------------------------------
// rbb_window_mem
// Pixel window store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rbb_window_mem #(
    parameter int DEPTH  = rbb_pkg::DEF_WINDOW_DEPTH,
    parameter int DATA_W = rbb_pkg::PIX_W * rbb_pkg::DEF_CHANNELS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);
    import rbb_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/rbb_divider.sv]
// ----------------------------------------------------------------------------
// rbb_divider
// Restoring divider, one quotient bit per cycle, lanes sharing a divisor.
// The quotient is known to fit in one pixel byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbb_divider #(
    parameter int LANES = rbb_pkg::DEF_CHANNELS,
    parameter int NUM_W = 16,
    parameter int DEN_W = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [LANES-1:0][NUM_W-1:0]          i_num,
    input  logic [DEN_W-1:0]                     i_den,
    output rbb_pkg::t_div_stat                   o_stat,
    output logic [LANES-1:0][rbb_pkg::PIX_W-1:0] o_quot
);
    import rbb_pkg::*;

    localparam int QUOT_W = PIX_W;
    localparam int STEP_W = $clog2(QUOT_W);
    localparam int CMP_W  = (NUM_W > DEN_W + QUOT_W - 1) ? NUM_W : DEN_W + QUOT_W - 1;

    logic                          r_busy;
    logic                          r_done;
    logic [STEP_W-1:0]             r_step;
    logic [LANES-1:0][NUM_W-1:0]   r_rem;
    logic [CMP_W-1:0]              r_den_sh;
    logic [LANES-1:0][QUOT_W-1:0]  r_quot;
    logic [LANES-1:0][NUM_W-1:0]   n_rem;
    logic [LANES-1:0]              n_bit;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (CMP_W'(r_rem[l]) >= r_den_sh) begin
                n_rem[l] = NUM_W'(CMP_W'(r_rem[l]) - r_den_sh);
                n_bit[l] = 1'b1;
            end else begin
                n_rem[l] = r_rem[l];
                n_bit[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem    <= i_num;
            r_den_sh <= CMP_W'(i_den) << (QUOT_W - 1);
            r_quot   <= '0;
        end else if (r_busy) begin
            r_rem    <= n_rem;
            r_den_sh <= r_den_sh >> 1;
            for (int l = 0; l < LANES; l++) begin
                r_quot[l] <= {r_quot[l][QUOT_W-2:0], n_bit[l]};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

    `RBB_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, !r_busy, "divider restarted while busy")
    `RBB_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy, "divider did not start")
    `RBB_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done && !r_busy,
                    "divider done not a single pulse")

endmodule

[src/row_box_blur_edge_cropped.sv]
// ----------------------------------------------------------------------------
// row_box_blur_edge_cropped
// Horizontal box blur of 4-channel 8-bit pixels, window clipped to the row.
// Pixels are written into a window memory at the incoming column; running
// per-channel sums add each entering pixel, and the leaving pixel is read back
// from the memory and subtracted after each result whose window is not clipped
// at the row start. Each result is the rounded half-up mean (2*sum + n) / (2*n)
// from a bit-serial divider, 8 steps a result. An item is taken in the idle
// state and checked; each result it releases passes the check, divide and emit
// states, and the emit state waits while the output register is still full.
// A finished result waits in an output register while the next item is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module row_box_blur_edge_cropped #(
    parameter int MAX_RADIUS    = rbb_pkg::DEF_MAX_RADIUS,
    parameter int WINDOW_DEPTH  = rbb_pkg::DEF_WINDOW_DEPTH,
    parameter int MAX_ROW_WIDTH = rbb_pkg::DEF_MAX_ROW_WIDTH,
    parameter int CHANNELS      = rbb_pkg::DEF_CHANNELS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [rbb_pkg::PIX_W-1:0]      i_ch0_in,
    input  logic [rbb_pkg::PIX_W-1:0]      i_ch1_in,
    input  logic [rbb_pkg::PIX_W-1:0]      i_ch2_in,
    input  logic [rbb_pkg::PIX_W-1:0]      i_ch3_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rbb_pkg::PIX_W-1:0]      o_ch0_out,
    output logic [rbb_pkg::PIX_W-1:0]      o_ch1_out,
    output logic [rbb_pkg::PIX_W-1:0]      o_ch2_out,
    output logic [rbb_pkg::PIX_W-1:0]      o_ch3_out,
    output logic                           o_last_in_run,
    output logic                           o_row_end,
    output logic                           o_frame_end
);
    import rbb_pkg::*;

    localparam int RR_LIMIT = (MAX_RADIUS < (WINDOW_DEPTH - 1) / 2) ?
                              MAX_RADIUS : (WINDOW_DEPTH - 1) / 2;
    localparam int RR_W     = $clog2(RR_LIMIT + 1);
    localparam int X_W      = $clog2(MAX_ROW_WIDTH);
    localparam int OC_W     = X_W + 1;
    localparam int EXT_W    = ((OC_W > RR_W) ? OC_W : RR_W) + 2;
    localparam int SUM_W    = $clog2(PIX_MAX * (2 * RR_LIMIT + 1) + 1);
    localparam int CNT_W    = $clog2(2 * RR_LIMIT + 2);
    localparam int NUM_W    = SUM_W + 2;
    localparam int DEN_W    = CNT_W + 1;
    localparam int AW       = $clog2(WINDOW_DEPTH);
    localparam int MEM_W    = PIX_W * CHANNELS;

    t_state                          r_state;
    t_state                          n_state;
    logic [RADIUS_W-1:0]             r_radius;
    logic [SIZE_W-1:0]               r_row_width;
    logic [SIZE_W-1:0]               r_row_count;
    logic [X_W-1:0]                  r_in_col;
    logic [OC_W-1:0]                 r_out_col;
    logic [X_W-1:0]                  r_row_idx;
    logic [CHANNELS-1:0][SUM_W-1:0]  r_sums;
    logic [AW-1:0]                   r_wr_ptr;
    logic [AW-1:0]                   r_rd_ptr;
    logic                            r_out_valid;
    logic [NUM_PORT_CH-1:0][PIX_W-1:0] r_q;
    logic                            r_last_in_run;
    logic                            r_row_end;
    logic                            r_frame_end;

    logic [OC_W-1:0]                 w_lim;
    logic [OC_W-1:0]                 h_lim;
    logic [RR_W-1:0]                 rr;
    logic [EXT_W-1:0]                x_e;
    logic [EXT_W-1:0]                oc_e;
    logic [EXT_W-1:0]                rr_e;
    logic [EXT_W-1:0]                lo;
    logic [EXT_W-1:0]                hi;
    logic [CNT_W-1:0]                cnt;
    logic                            last;
    logic                            emit_ok;
    logic                            next_ok;
    logic                            sub_ok;
    logic                            row_end_now;
    logic                            row_last;
    logic                            cfg_hit;
    logic                            out_free;

    logic                            in_ready;
    logic                            accept;
    logic                            div_start;
    logic                            emit_load;
    logic                            finish;

    logic [NUM_PORT_CH-1:0][PIX_W-1:0] in4;
    logic [NUM_PORT_CH-1:0][PIX_W-1:0] quot4;
    logic [MEM_W-1:0]                mem_wdata;
    logic [MEM_W-1:0]                mem_rdata;
    logic [CHANNELS-1:0][NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]                div_den;
    t_div_stat                       div_stat;
    logic [CHANNELS-1:0][PIX_W-1:0]  div_q;

    assign in4       = {i_ch3_in, i_ch2_in, i_ch1_in, i_ch0_in};
    assign mem_wdata = in4[CHANNELS-1:0];

    // clipped sizes and radius in use
    always_comb begin
        if (r_row_width == '0) begin
            w_lim = OC_W'(1);
        end else if (32'(r_row_width) > 32'(MAX_ROW_WIDTH)) begin
            w_lim = OC_W'(MAX_ROW_WIDTH);
        end else begin
            w_lim = OC_W'(r_row_width);
        end
        if (r_row_count == '0) begin
            h_lim = OC_W'(1);
        end else if (32'(r_row_count) > 32'(MAX_ROW_WIDTH)) begin
            h_lim = OC_W'(MAX_ROW_WIDTH);
        end else begin
            h_lim = OC_W'(r_row_count);
        end
        if (32'(r_radius) > 32'(RR_LIMIT)) begin
            rr = RR_W'(RR_LIMIT);
        end else begin
            rr = RR_W'(r_radius);
        end
    end

    always_comb begin
        x_e         = EXT_W'(r_in_col);
        oc_e        = EXT_W'(r_out_col);
        rr_e        = EXT_W'(rr);
        last        = (x_e + EXT_W'(1)) >= EXT_W'(w_lim);
        emit_ok     = (oc_e <= x_e) && (last || (x_e >= oc_e + rr_e));
        next_ok     = (oc_e + EXT_W'(1) <= x_e) &&
                      (last || (x_e >= oc_e + EXT_W'(1) + rr_e));
        sub_ok      = oc_e >= rr_e;
        lo          = sub_ok ? oc_e - rr_e : '0;
        hi          = (oc_e + rr_e < x_e) ? oc_e + rr_e : x_e;
        cnt         = CNT_W'(hi - lo + EXT_W'(1));
        row_end_now = last && (oc_e == x_e);
        row_last    = (EXT_W'(r_row_idx) + EXT_W'(1)) >= EXT_W'(h_lim);
        out_free    = !r_out_valid || i_out_ready;
        cfg_hit     = i_cfg_we && ((i_cfg_idx == CFG_RADIUS) ||
                                   (i_cfg_idx == CFG_ROW_WIDTH) ||
                                   (i_cfg_idx == CFG_ROW_COUNT));
    end

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            div_num[c] = (NUM_W'(r_sums[c]) << 1) + NUM_W'(cnt);
        end
        div_den = {cnt, 1'b0};
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = emit_ok ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_CHECK;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        emit_load = 1'b0;
        finish    = 1'b0;
        unique case (r_state)
            ST_IDLE:  in_ready  = 1'b1;
            ST_CHECK: begin
                div_start = emit_ok;
                finish    = !emit_ok;
            end
            ST_DIV:   ;
            ST_EMIT:  emit_load = out_free;
            default:  ;
        endcase
        accept = in_ready && i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RST_RADIUS;
            r_row_width <= RST_ROW_WIDTH;
            r_row_count <= RST_ROW_COUNT;
            r_in_col    <= '0;
            r_out_col   <= '0;
            r_row_idx   <= '0;
            r_sums      <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
        end else if (cfg_hit) begin
            unique case (i_cfg_idx)
                CFG_RADIUS:    r_radius    <= i_cfg_data[RADIUS_W-1:0];
                CFG_ROW_WIDTH: r_row_width <= i_cfg_data[SIZE_W-1:0];
                CFG_ROW_COUNT: r_row_count <= i_cfg_data[SIZE_W-1:0];
                default:       ;
            endcase
            r_in_col  <= '0;
            r_out_col <= '0;
            r_row_idx <= '0;
            r_sums    <= '0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
        end else begin
            if (accept) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    r_sums[c] <= r_sums[c] + SUM_W'(in4[c]);
                end
                r_wr_ptr <= (r_wr_ptr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (emit_load) begin
                if (sub_ok) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        r_sums[c] <= r_sums[c] - SUM_W'(mem_rdata[PIX_W*c +: PIX_W]);
                    end
                    r_rd_ptr <= (r_rd_ptr == AW'(WINDOW_DEPTH - 1)) ?
                                '0 : r_rd_ptr + AW'(1);
                end
                r_out_col <= r_out_col + OC_W'(1);
            end
            if (finish) begin
                if (last) begin
                    r_in_col  <= '0;
                    r_out_col <= '0;
                    r_sums    <= '0;
                    r_wr_ptr  <= '0;
                    r_rd_ptr  <= '0;
                    r_row_idx <= row_last ? '0 : r_row_idx + X_W'(1);
                end else begin
                    r_in_col <= r_in_col + X_W'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_q           <= quot4;
            r_last_in_run <= !next_ok;
            r_row_end     <= row_end_now;
            r_frame_end   <= row_end_now && row_last;
        end
    end

    for (genvar g = 0; g < NUM_PORT_CH; g++) begin : g_quot
        if (g < CHANNELS) begin : g_on
            assign quot4[g] = div_q[g];
        end else begin : g_off
            assign quot4[g] = '0;
        end
    end

    rbb_window_mem #(
        .DEPTH  (WINDOW_DEPTH),
        .DATA_W (MEM_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wr_ptr),
        .i_wdata (mem_wdata),
        .i_re    (div_start),
        .i_raddr (r_rd_ptr),
        .o_rdata (mem_rdata)
    );

    rbb_divider #(
        .LANES (CHANNELS),
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_q)
    );

    assign o_in_ready    = in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_ch0_out     = r_q[0];
    assign o_ch1_out     = r_q[1];
    assign o_ch2_out     = r_q[2];
    assign o_ch3_out     = r_q[3];
    assign o_last_in_run = r_last_in_run;
    assign o_row_end     = r_row_end;
    assign o_frame_end   = r_frame_end;

    `RBB_ASSERT_IMP(a_col_order, i_clk, i_rst_n, r_state == ST_IDLE,
                    r_out_col <= OC_W'(r_in_col), "output column ran ahead of input")
    `RBB_ASSERT_IMP(a_done_in_div, i_clk, i_rst_n, div_stat.done, r_state == ST_DIV,
                    "divider result outside divide state")
    `RBB_ASSERT_IMP(a_busy_in_div, i_clk, i_rst_n, div_stat.busy, r_state == ST_DIV,
                    "divider busy outside divide state")
    `RBB_ASSERT_NXT(a_emit_hold, i_clk, i_rst_n,
                    r_state == ST_EMIT && r_out_valid && !i_out_ready,
                    r_state == ST_EMIT, "result dropped over a full output register")

endmodule
